// ===== sv/cxa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cxa_pkg;

    // Word format of the accumulator and the operands.
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;

    // Request codes; the two unused codes act as length only.
    typedef enum logic [2:0] {
        REQ_LOAD  = 3'd0,
        REQ_ADD   = 3'd1,
        REQ_SUB   = 3'd2,
        REQ_MUL   = 3'd3,
        REQ_DIV   = 3'd4,
        REQ_LEN   = 3'd5,
        REQ_RSV6  = 3'd6,
        REQ_RSV7  = 3'd7
    } req_e;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_COMBINE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [2:0]                  req_type;
        logic signed [WORD_BITS-1:0] operand_re;
        logic signed [WORD_BITS-1:0] operand_im;
    } in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] acc_re;
        logic signed [WORD_BITS-1:0] acc_im;
        logic [WORD_BITS-1:0]        magnitude;
        logic                        divide_by_zero;
    } out_t;

    // A value held as a sign and a magnitude.
    typedef struct packed {
        logic                 neg;
        logic [PROD_BITS-1:0] mag;
    } sm_t;

    localparam logic [PROD_BITS-1:0] WMAX_EXT = {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};

    // Magnitude of a signed word.
    function automatic logic [WORD_BITS-1:0] abs_word(input logic signed [WORD_BITS-1:0] v);
        abs_word = v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // Exact sum of two sign-magnitude values.
    function automatic sm_t sm_add(input logic np, input logic [PROD_BITS-1:0] mp,
                                   input logic nq, input logic [PROD_BITS-1:0] mq);
        sm_t r;
        if (np == nq) begin
            r.neg = np;
            r.mag = mp + mq;
        end else if (mp >= mq) begin
            r.neg = np;
            r.mag = mp - mq;
        end else begin
            r.neg = nq;
            r.mag = mq - mp;
        end
        if (r.mag == '0) begin
            r.neg = 1'b0;
        end
        sm_add = r;
    endfunction

    // Signed word from a sign and a magnitude, saturated.
    function automatic logic signed [WORD_BITS-1:0] from_sm(input logic neg,
                                                           input logic [PROD_BITS-1:0] mag);
        logic signed [WORD_BITS-1:0] r;
        if (neg) begin
            if (mag > WMAX_EXT) begin
                r = {1'b1, {(WORD_BITS-1){1'b0}}};
            end else begin
                r = ~mag[WORD_BITS-1:0] + 1'b1;
            end
        end else begin
            if (mag > WMAX_EXT) begin
                r = {1'b0, {(WORD_BITS-1){1'b1}}};
            end else begin
                r = mag[WORD_BITS-1:0];
            end
        end
        from_sm = r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cxa_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cxa_mul (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [cxa_pkg::WORD_BITS-1:0]  mcand,
    input  wire logic [cxa_pkg::WORD_BITS-1:0]  mplr,
    output logic                                done,
    output logic [cxa_pkg::PROD_BITS-1:0]       product
);

    localparam int W = cxa_pkg::WORD_BITS;

    logic [W-1:0] hi_reg, lo_reg, mc_reg;
    logic [4:0]   cnt_reg;
    logic         run_reg, done_reg;
    logic [W:0]   sum;

    // One multiplier bit per cycle: add the multiplicand, shift right.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mc_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                hi_reg  <= '0;
                lo_reg  <= mplr;
                mc_reg  <= mcand;
            end else if (run_reg) begin
                hi_reg  <= sum[W:1];
                lo_reg  <= {sum[0], lo_reg[W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'(W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ===== sv/cxa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cxa_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [cxa_pkg::PROD_BITS-1:0]  num,
    input  wire logic [cxa_pkg::PROD_BITS-1:0]  den,
    output logic                                done,
    output logic [cxa_pkg::WORD_BITS:0]         q_mag
);

    localparam int P     = cxa_pkg::PROD_BITS;
    localparam int W     = cxa_pkg::WORD_BITS;
    localparam int STEPS = P + cxa_pkg::FRAC_BITS + 1;
    localparam int QW    = W + 2;

    logic [P-1:0]  num_reg, den_reg, rem_reg;
    logic [QW-1:0] q_reg;
    logic          ovf_reg, run_reg, done_reg;
    logic [6:0]    cnt_reg;
    logic [P:0]    shifted;
    logic          fits;
    logic          ovf;
    logic [QW-1:0] q_inc;

    // Restoring division, one quotient bit per cycle, with the numerator
    // padded by the fraction bits plus one rounding bit.
    assign shifted = {rem_reg, num_reg[P-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                q_reg   <= '0;
                ovf_reg <= 1'b0;
            end else if (run_reg) begin
                num_reg <= {num_reg[P-2:0], 1'b0};
                rem_reg <= fits ? P'(shifted - {1'b0, den_reg}) : shifted[P-1:0];
                q_reg   <= {q_reg[QW-2:0], fits};
                ovf_reg <= ovf_reg | q_reg[QW-1];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 7'(STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // A quotient of a whole word or more is capped; otherwise round.
    assign ovf   = ovf_reg | q_reg[QW-1];
    assign q_inc = {1'b0, q_reg[QW-2:0]} + 1'b1;
    assign q_mag = ovf ? {1'b1, {W{1'b0}}} : q_inc[QW-1:1];
    assign done  = done_reg;

endmodule

`default_nettype wire

// ===== sv/cxa_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cxa_sqrt (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [cxa_pkg::PROD_BITS-1:0]  radicand,
    output logic                                done,
    output logic [cxa_pkg::WORD_BITS:0]         root
);

    localparam int P  = cxa_pkg::PROD_BITS;
    localparam int W  = cxa_pkg::WORD_BITS;
    localparam int RW = W + 4;

    logic [P-1:0]  n_reg;
    logic [RW-1:0] rem_reg;
    logic [W-1:0]  root_reg;
    logic [4:0]    cnt_reg;
    logic          run_reg, done_reg;
    logic [RW-1:0] rs, trial;
    logic          fits;

    // Two radicand bits per cycle, one root bit per cycle.
    assign rs    = {rem_reg[RW-3:0], n_reg[P-1:P-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = rs >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                cnt_reg  <= '0;
                n_reg    <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (run_reg) begin
                n_reg    <= {n_reg[P-3:0], 2'b00};
                rem_reg  <= fits ? rs - trial : rs;
                root_reg <= {root_reg[W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == 5'(W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Round to nearest: the remainder beyond the root means a half or more.
    assign root = (rem_reg > {4'b0000, root_reg}) ? ({1'b0, root_reg} + 1'b1)
                                                   : {1'b0, root_reg};
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/complex_accumulator_alu.sv =====
// Complex accumulator ALU with a signed Q16.16 accumulator.
// Input channel s_valid/s_ready/s_data carries a request code and a complex
// operand; output channel m_valid/m_ready/m_data returns one result per
// request: the accumulator after the request, its rounded magnitude and a
// divide-by-zero flag.
// Products, quotients and the magnitude run through bit-serial units: a
// shift-add multiplier with 32 steps, a restoring divider with 81 steps and
// a square-root unit with 32 steps. Load, add, subtract and length use two
// products and one root, multiply uses six products and one root, and
// divide by a nonzero operand uses eight products, two quotients and one root.
// One request is worked on at a time; s_ready is high only when the
// sequencer is idle, so a new request is taken only after the previous
// result has entered the output register.
// The finished result sits in an output register, so the next request is
// taken while m_valid waits for m_ready; a second result waits in the
// sequencer until that register is free.
// Synchronous active-low reset clears the accumulator to zero and drops
// m_valid.
`timescale 1ns / 1ps
`default_nettype none

module complex_accumulator_alu (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cxa_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cxa_pkg::out_t      m_data
);

    localparam int W = cxa_pkg::WORD_BITS;
    localparam int P = cxa_pkg::PROD_BITS;
    localparam int F = cxa_pkg::FRAC_BITS;

    cxa_pkg::state_t state_reg, state_next;

    logic signed [W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [2:0]          req_reg;
    logic [2:0]          job_reg;
    logic                mag_reg, flag_reg, div_im_reg;
    logic [P-1:0]        prod_reg [0:5];
    cxa_pkg::sm_t        num_re_reg, num_im_reg;
    logic [P-1:0]        den_reg;
    logic [W:0]          q_re_reg;
    cxa_pkg::out_t       out_reg;
    logic                m_valid_reg;

    logic                mul_start, mul_done;
    logic                div_start, div_done;
    logic                sqrt_start, sqrt_done;
    logic [W-1:0]        mul_x, mul_y;
    logic [P-1:0]        mul_p;
    logic [W:0]          div_q;
    logic [W:0]          sqrt_root;
    logic                out_load;
    logic                op_zero;
    logic [2:0]          job_last;
    logic                sa, sb, sc, sd;

    // Saturate a sum that grew by one bit.
    function automatic logic signed [W-1:0] sat_word(input logic [W:0] s);
        if (s[W] != s[W-1]) begin
            sat_word = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            sat_word = s[W-1:0];
        end
    endfunction

    // Serial arithmetic units.
    cxa_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_x),
        .mplr    (mul_y),
        .done    (mul_done),
        .product (mul_p)
    );

    cxa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_im_reg ? num_im_reg.mag : num_re_reg.mag),
        .den     (den_reg),
        .done    (div_done),
        .q_mag   (div_q)
    );

    cxa_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (prod_reg[4] + prod_reg[5]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign sa      = a_reg[W-1];
    assign sb      = b_reg[W-1];
    assign sc      = c_reg[W-1];
    assign sd      = d_reg[W-1];
    assign op_zero = (c_reg == '0) && (d_reg == '0);
    assign job_last = (!mag_reg && (req_reg == cxa_pkg::REQ_MUL)) ? 3'd3 : 3'd5;

    // Operand pair of each product job.
    always_comb begin
        case (job_reg)
            3'd0: begin
                mul_x = cxa_pkg::abs_word(a_reg);
                mul_y = cxa_pkg::abs_word(c_reg);
            end
            3'd1: begin
                mul_x = cxa_pkg::abs_word(b_reg);
                mul_y = cxa_pkg::abs_word(d_reg);
            end
            3'd2: begin
                mul_x = cxa_pkg::abs_word(a_reg);
                mul_y = cxa_pkg::abs_word(d_reg);
            end
            3'd3: begin
                mul_x = cxa_pkg::abs_word(b_reg);
                mul_y = cxa_pkg::abs_word(c_reg);
            end
            3'd4: begin
                mul_x = cxa_pkg::abs_word(mag_reg ? a_reg : c_reg);
                mul_y = mul_x;
            end
            default: begin
                mul_x = cxa_pkg::abs_word(mag_reg ? b_reg : d_reg);
                mul_y = mul_x;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cxa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = cxa_pkg::ST_DISPATCH;
                end
            end
            cxa_pkg::ST_DISPATCH:   state_next = cxa_pkg::ST_MUL_START;
            cxa_pkg::ST_MUL_START:  state_next = cxa_pkg::ST_MUL_WAIT;
            cxa_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    state_next = (job_reg == job_last) ? cxa_pkg::ST_COMBINE
                                                       : cxa_pkg::ST_MUL_START;
                end
            end
            cxa_pkg::ST_COMBINE: begin
                if (mag_reg) begin
                    state_next = cxa_pkg::ST_SQRT_START;
                end else if (req_reg == cxa_pkg::REQ_MUL) begin
                    state_next = cxa_pkg::ST_MUL_START;
                end else begin
                    state_next = cxa_pkg::ST_DIV_START;
                end
            end
            cxa_pkg::ST_DIV_START:  state_next = cxa_pkg::ST_DIV_WAIT;
            cxa_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = div_im_reg ? cxa_pkg::ST_MUL_START : cxa_pkg::ST_DIV_START;
                end
            end
            cxa_pkg::ST_SQRT_START: state_next = cxa_pkg::ST_SQRT_WAIT;
            cxa_pkg::ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    state_next = cxa_pkg::ST_FLUSH;
                end
            end
            cxa_pkg::ST_FLUSH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = cxa_pkg::ST_IDLE;
                end
            end
            default: state_next = cxa_pkg::ST_IDLE;
        endcase
    end

    // Strobes decoded from the state.
    always_comb begin
        s_ready    = (state_reg == cxa_pkg::ST_IDLE);
        mul_start  = (state_reg == cxa_pkg::ST_MUL_START);
        div_start  = (state_reg == cxa_pkg::ST_DIV_START);
        sqrt_start = (state_reg == cxa_pkg::ST_SQRT_START);
        out_load   = (state_reg == cxa_pkg::ST_FLUSH) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cxa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath and accumulator.
    always_ff @(posedge aclk) begin
        logic [W:0]   sum;
        cxa_pkg::sm_t t_re, t_im;
        if (!aresetn) begin
            a_reg <= '0;
            b_reg <= '0;
        end else begin
            case (state_reg)
                cxa_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        req_reg <= s_data.req_type;
                        c_reg   <= s_data.operand_re;
                        d_reg   <= s_data.operand_im;
                    end
                end
                cxa_pkg::ST_DISPATCH: begin
                    flag_reg <= 1'b0;
                    if (req_reg == cxa_pkg::REQ_MUL ||
                        (req_reg == cxa_pkg::REQ_DIV && !op_zero)) begin
                        job_reg <= 3'd0;
                        mag_reg <= 1'b0;
                    end else begin
                        job_reg <= 3'd4;
                        mag_reg <= 1'b1;
                        case (req_reg)
                            cxa_pkg::REQ_LOAD: begin
                                a_reg <= c_reg;
                                b_reg <= d_reg;
                            end
                            cxa_pkg::REQ_ADD: begin
                                sum = {a_reg[W-1], a_reg} + {c_reg[W-1], c_reg};
                                a_reg <= sat_word(sum);
                                sum = {b_reg[W-1], b_reg} + {d_reg[W-1], d_reg};
                                b_reg <= sat_word(sum);
                            end
                            cxa_pkg::REQ_SUB: begin
                                sum = {a_reg[W-1], a_reg} - {c_reg[W-1], c_reg};
                                a_reg <= sat_word(sum);
                                sum = {b_reg[W-1], b_reg} - {d_reg[W-1], d_reg};
                                b_reg <= sat_word(sum);
                            end
                            cxa_pkg::REQ_DIV: flag_reg <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                cxa_pkg::ST_MUL_WAIT: begin
                    if (mul_done) begin
                        prod_reg[job_reg] <= mul_p;
                        if (job_reg != job_last) begin
                            job_reg <= job_reg + 1'b1;
                        end
                    end
                end
                cxa_pkg::ST_COMBINE: begin
                    if (!mag_reg && req_reg == cxa_pkg::REQ_MUL) begin
                        // Real A*C-B*D and imaginary A*D+B*C, rounded.
                        t_re = cxa_pkg::sm_add(sa ^ sc, prod_reg[0], !(sb ^ sd), prod_reg[1]);
                        t_im = cxa_pkg::sm_add(sa ^ sd, prod_reg[2], sb ^ sc, prod_reg[3]);
                        a_reg <= cxa_pkg::from_sm(t_re.neg,
                                     (t_re.mag + (P'(1) << (F - 1))) >> F);
                        b_reg <= cxa_pkg::from_sm(t_im.neg,
                                     (t_im.mag + (P'(1) << (F - 1))) >> F);
                        mag_reg <= 1'b1;
                        job_reg <= 3'd4;
                    end else if (!mag_reg) begin
                        // Quotient numerators and denominator.
                        num_re_reg <= cxa_pkg::sm_add(sa ^ sc, prod_reg[0], sb ^ sd, prod_reg[1]);
                        num_im_reg <= cxa_pkg::sm_add(sb ^ sc, prod_reg[3],
                                                      !(sa ^ sd), prod_reg[2]);
                        den_reg    <= prod_reg[4] + prod_reg[5];
                        div_im_reg <= 1'b0;
                    end
                end
                cxa_pkg::ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (!div_im_reg) begin
                            q_re_reg   <= div_q;
                            div_im_reg <= 1'b1;
                        end else begin
                            a_reg   <= cxa_pkg::from_sm(num_re_reg.neg, P'(q_re_reg));
                            b_reg   <= cxa_pkg::from_sm(num_im_reg.neg, P'(div_q));
                            mag_reg <= 1'b1;
                            job_reg <= 3'd4;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register; a result transfers out while the next request runs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg            <= 1'b1;
            out_reg.acc_re         <= a_reg;
            out_reg.acc_im         <= b_reg;
            out_reg.magnitude      <= sqrt_root[W-1:0];
            out_reg.divide_by_zero <= flag_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
